// ===== rtl/rgbhsl_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the RGB to HSL converter.
package rgbhsl_pkg;

    localparam int CHAN_W = 8;
    localparam int HUE_W  = 9;
    localparam int SUM_W  = 9;
    // 60*diff + 240*delta + 360*delta fits in 18 bits
    localparam int HNUM_W = 18;

    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

endpackage

// ===== rtl/rgbhsl_front.sv =====
`timescale 1ns / 1ps
// Front stage: max, min, delta, sums and the hue numerator of one pixel.
module rgbhsl_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic                               in_valid,
    input  logic [rgbhsl_pkg::CHAN_W-1:0]      red,
    input  logic [rgbhsl_pkg::CHAN_W-1:0]      green,
    input  logic [rgbhsl_pkg::CHAN_W-1:0]      blue,
    output logic                               out_valid,
    output logic [rgbhsl_pkg::CHAN_W-1:0]      delta,
    output logic [rgbhsl_pkg::SUM_W-1:0]       sum,
    output logic [rgbhsl_pkg::SUM_W-1:0]       den,
    output logic [rgbhsl_pkg::HNUM_W-1:0]      hnum
);
    logic                           valid_reg;
    logic [rgbhsl_pkg::CHAN_W-1:0]  delta_reg, delta_next;
    logic [rgbhsl_pkg::SUM_W-1:0]   sum_reg, sum_next, den_reg, den_next;
    logic [rgbhsl_pkg::HNUM_W-1:0]  hnum_reg, hnum_next;
    logic [rgbhsl_pkg::CHAN_W-1:0]  mx, mn;
    logic [1:0]                     sel;
    logic signed [rgbhsl_pkg::HNUM_W:0] diff, num;

    always_comb
    begin
        if (red >= green && red >= blue)
        begin
            sel = rgbhsl_pkg::SEL_RED;
            mx  = red;
        end
        else if (green >= blue)
        begin
            sel = rgbhsl_pkg::SEL_GREEN;
            mx  = green;
        end
        else
        begin
            sel = rgbhsl_pkg::SEL_BLUE;
            mx  = blue;
        end
        mn = (red <= green) ? ((red <= blue) ? red : blue) : ((green <= blue) ? green : blue);
        delta_next = mx - mn;
        sum_next   = {1'b0, mx} + {1'b0, mn};
        den_next   = (sum_next <= 9'd255) ? sum_next : (9'd510 - sum_next);
        case (sel)
            rgbhsl_pkg::SEL_RED:
                diff = $signed({11'd0, green}) - $signed({11'd0, blue});
            rgbhsl_pkg::SEL_GREEN:
                diff = $signed({11'd0, blue}) - $signed({11'd0, red})
                     + $signed({10'd0, delta_next, 1'b0});
            default:
                diff = $signed({11'd0, red}) - $signed({11'd0, green})
                     + $signed({9'd0, delta_next, 2'b0});
        endcase
        // 60*diff, wrap negative hue by adding 360*delta
        num = (diff <<< 6) - (diff <<< 2);
        if (num < 0)
            num = num + $signed({11'd0, delta_next}) * 19'sd360;
        hnum_next = num[rgbhsl_pkg::HNUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            delta_reg <= delta_next;
            sum_reg   <= sum_next;
            den_reg   <= den_next;
            hnum_reg  <= hnum_next;
        end
    end

    assign out_valid = valid_reg;
    assign delta     = delta_reg;
    assign sum       = sum_reg;
    assign den       = den_reg;
    assign hnum      = hnum_reg;
endmodule

// ===== rtl/rgbhsl_cell.sv =====
`timescale 1ns / 1ps
// One restoring-division cell: produce one saturation quotient bit and, in a hue cell, one hue quotient bit.
module rgbhsl_cell
#(
    parameter int QS_W = 17,
    parameter int BIT  = 0,
    parameter int IDX  = 0
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_valid,
    input  logic [rgbhsl_pkg::HNUM_W-1:0]     in_hrem,
    input  logic [rgbhsl_pkg::HUE_W-1:0]      in_hq,
    input  logic [rgbhsl_pkg::SUM_W-1:0]      in_srem,
    input  logic [QS_W-1:0]                   in_sq,
    input  logic [rgbhsl_pkg::CHAN_W-1:0]     in_delta,
    input  logic [rgbhsl_pkg::SUM_W-1:0]      in_den,
    input  logic [QS_W-1:0]                   in_light,
    output logic                              out_valid,
    output logic [rgbhsl_pkg::HNUM_W-1:0]     out_hrem,
    output logic [rgbhsl_pkg::HUE_W-1:0]      out_hq,
    output logic [rgbhsl_pkg::SUM_W-1:0]      out_srem,
    output logic [QS_W-1:0]                   out_sq,
    output logic [rgbhsl_pkg::CHAN_W-1:0]     out_delta,
    output logic [rgbhsl_pkg::SUM_W-1:0]      out_den,
    output logic [QS_W-1:0]                   out_light
);
    localparam int HW = rgbhsl_pkg::HNUM_W;
    // hue bit index kept in range for cells past the hue bits
    localparam int HB = (BIT < rgbhsl_pkg::HUE_W) ? BIT : 0;
    logic                  valid_reg;
    logic [HW-1:0]         hrem_reg, hrem_next;
    logic [rgbhsl_pkg::HUE_W-1:0] hq_reg, hq_next;
    logic [rgbhsl_pkg::SUM_W-1:0] srem_reg, srem_next;
    logic [QS_W-1:0]       sq_reg, sq_next;
    logic [rgbhsl_pkg::CHAN_W-1:0] delta_reg;
    logic [rgbhsl_pkg::SUM_W-1:0]  den_reg;
    logic [QS_W-1:0]       light_reg;
    logic [HW+rgbhsl_pkg::CHAN_W-1:0] hsub;
    logic [rgbhsl_pkg::SUM_W:0]       sshift;

    always_comb
    begin
        hq_next   = in_hq;
        hrem_next = in_hrem;
        if (BIT < rgbhsl_pkg::HUE_W)
        begin
            hsub = {{HW{1'b0}}, in_delta} << HB;
            if ({{rgbhsl_pkg::CHAN_W{1'b0}}, in_hrem} >= hsub)
            begin
                hrem_next = in_hrem - hsub[HW-1:0];
                hq_next[HB] = 1'b1;
            end
        end
        else
            hsub = '0;
        // saturation: delta/den <= 1, long division one bit per cell, MSB first
        sq_next = in_sq;
        if (IDX == 0)
            sshift = {1'b0, in_srem};
        else
            sshift = {in_srem, 1'b0};
        if (sshift >= {1'b0, in_den} && in_den != '0)
        begin
            srem_next = sshift[rgbhsl_pkg::SUM_W-1:0] - in_den;
            sq_next[QS_W-1-IDX] = 1'b1;
        end
        else
            srem_next = sshift[rgbhsl_pkg::SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hrem_reg  <= hrem_next;
            hq_reg    <= hq_next;
            srem_reg  <= srem_next;
            sq_reg    <= sq_next;
            delta_reg <= in_delta;
            den_reg   <= in_den;
            light_reg <= in_light;
        end
    end

    assign out_valid = valid_reg;
    assign out_hrem  = hrem_reg;
    assign out_hq    = hq_reg;
    assign out_srem  = srem_reg;
    assign out_sq    = sq_reg;
    assign out_delta = delta_reg;
    assign out_den   = den_reg;
    assign out_light = light_reg;
endmodule

// ===== rtl/rgb_to_hsl_convert.sv =====
`timescale 1ns / 1ps
// Top level of the RGB to HSL converter.
// One pixel is accepted every clock cycle while the output is not stalled. A
// front stage finds max, min and delta, then a row of FRACTION_BITS+1
// division cells each yields one saturation quotient bit (and one hue bit,
// MSB first, in its first nine cells), then an output register.
// Lightness is (max+min)*2^F/510, estimated by shifts and adds and corrected by
// one either way in the front of the row. A stalled output holds the whole row.
module rgb_to_hsl_convert
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata, // red, green, blue
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // hue_deg, saturation, lightness, zero fill
    output logic [((9+2*(FRACTION_BITS+1)+7)/8)*8-1:0] m_tdata
);
    localparam int QS_W  = FRACTION_BITS + 1;
    localparam int NCELL = QS_W;
    localparam int OUT_W = ((9 + 2 * QS_W + 7) / 8) * 8;
    localparam int HW    = rgbhsl_pkg::HNUM_W;

    logic advance;
    logic f_valid;
    logic [7:0] f_delta;
    logic [8:0] f_sum, f_den;
    logic [HW-1:0] f_hnum;
    logic [QS_W-1:0] f_light;

    logic          c_valid [0:NCELL];
    logic [HW-1:0] c_hrem  [0:NCELL];
    logic [8:0]    c_hq    [0:NCELL];
    logic [8:0]    c_srem  [0:NCELL];
    logic [QS_W-1:0] c_sq  [0:NCELL];
    logic [7:0]    c_delta [0:NCELL];
    logic [8:0]    c_den   [0:NCELL];
    logic [QS_W-1:0] c_light [0:NCELL];

    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg;
    logic [8:0]           hue_fin;
    logic [QS_W-1:0]      sat_fin;
    logic [QS_W+9+1:0]    lprod;

    // hold the whole row while a finished beat waits
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    rgbhsl_front u_front
    (
        .clk(clk), .rst_n(rst_n), .advance(advance),
        .in_valid(s_tvalid),
        .red(s_tdata[7:0]), .green(s_tdata[15:8]), .blue(s_tdata[23:16]),
        .out_valid(f_valid), .delta(f_delta), .sum(f_sum), .den(f_den),
        .hnum(f_hnum)
    );

    // floor(sum*2^F/510) = floor(sum*2^(F-1)/255); /255 by exact compare steps
    always_comb
    begin
        lprod = ({{(QS_W+2){1'b0}}, f_sum} << (FRACTION_BITS - 1));
        f_light = QS_W'((lprod + (lprod >> 8) + (lprod >> 16) + (lprod >> 24) + 1) >> 8);
        if ((({{(QS_W+1){1'b0}}, f_light} * 255) > lprod))
            f_light = f_light - 1'b1;
        else if (((({{(QS_W+1){1'b0}}, f_light} + 1) * 255) <= lprod))
            f_light = f_light + 1'b1;
    end

    assign c_valid[0] = f_valid;
    assign c_hrem[0]  = f_hnum;
    assign c_hq[0]    = '0;
    assign c_srem[0]  = {1'b0, f_delta};
    assign c_sq[0]    = '0;
    assign c_delta[0] = f_delta;
    assign c_den[0]   = f_den;
    assign c_light[0] = f_light;

    genvar i;
    generate
        for (i = 0; i < NCELL; i++)
        begin : g_cell
            rgbhsl_cell #(.QS_W(QS_W), .BIT((i < 9) ? 8 - i : 9), .IDX(i)) u_cell
            (
                .clk(clk), .rst_n(rst_n), .advance(advance),
                .in_valid(c_valid[i]), .in_hrem(c_hrem[i]), .in_hq(c_hq[i]),
                .in_srem(c_srem[i]), .in_sq(c_sq[i]), .in_delta(c_delta[i]),
                .in_den(c_den[i]), .in_light(c_light[i]),
                .out_valid(c_valid[i+1]), .out_hrem(c_hrem[i+1]),
                .out_hq(c_hq[i+1]), .out_srem(c_srem[i+1]), .out_sq(c_sq[i+1]),
                .out_delta(c_delta[i+1]), .out_den(c_den[i+1]),
                .out_light(c_light[i+1])
            );
        end
    endgenerate

    always_comb
    begin
        hue_fin = c_hq[NCELL];
        if (hue_fin >= 9'd360)
            hue_fin = hue_fin - 9'd360;
        sat_fin = c_sq[NCELL];
        if (c_delta[NCELL] == '0)
        begin
            hue_fin = '0;
            sat_fin = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= c_valid[NCELL];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= OUT_W'({c_light[NCELL], sat_fin, hue_fin});
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the RGB to HSL converter with a scoreboard class.
module tb_top;

    localparam int FB     = 16;
    localparam int SAT_W  = FB + 1;
    localparam int OUT_W  = ((9 + 2 * SAT_W + 7) / 8) * 8;
    localparam int LAT    = FB + 3;
    localparam int N_RAND = 1850;

    typedef struct packed {
        logic [8:0]       hue_deg;
        logic [SAT_W-1:0] saturation;
        logic [SAT_W-1:0] lightness;
    } hsl_t;

    class hsl_scoreboard;
        hsl_t pending[$];
        int   errors;

        function new();
            pending = {};
            errors  = 0;
        endfunction

        function hsl_t convert(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            hsl_t  res;
            int    mx;
            int    mn;
            int    dl;
            int    sm;
            int    den;
            longint num;
            longint one;
            mx  = int'(r);
            if (int'(g) > mx) mx = int'(g);
            if (int'(b) > mx) mx = int'(b);
            mn  = int'(r);
            if (int'(g) < mn) mn = int'(g);
            if (int'(b) < mn) mn = int'(b);
            dl  = mx - mn;
            sm  = mx + mn;
            one = 64'd1 << FB;
            res.lightness  = SAT_W'((sm * one) / 510);
            res.saturation = '0;
            res.hue_deg    = '0;
            if (dl != 0) begin
                den = (sm <= 255) ? sm : 510 - sm;
                res.saturation = SAT_W'((dl * one) / den);
                if (r == mx)
                    num = 60 * (int'(g) - int'(b));
                else if (g == mx)
                    num = 60 * (int'(b) - int'(r)) + 120 * dl;
                else
                    num = 60 * (int'(r) - int'(g)) + 240 * dl;
                if (num < 0)
                    num += 360 * dl;
                num = num / dl;
                if (num >= 360)
                    num -= 360;
                res.hue_deg = 9'(num);
            end
            return res;
        endfunction

        function void note_pixel(logic [23:0] px);
            pending.push_back(convert(px[7:0], px[15:8], px[23:16]));
        endfunction

        function void check_result(logic [OUT_W-1:0] d);
            hsl_t want;
            hsl_t got;
            got.hue_deg    = d[8:0];
            got.saturation = d[9 +: SAT_W];
            got.lightness  = d[9 + SAT_W +: SAT_W];
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, d);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.hue_deg != want.hue_deg) begin
                $display("%0t: hue exp %0d got %0d", $time, want.hue_deg, got.hue_deg);
                errors++;
            end
            if (got.saturation != want.saturation) begin
                $display("%0t: sat exp %0d got %0d", $time, want.saturation,
                         got.saturation);
                errors++;
            end
            if (got.lightness != want.lightness) begin
                $display("%0t: light exp %0d got %0d", $time, want.lightness,
                         got.lightness);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [23:0]      s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    bit               no_idle;
    hsl_scoreboard    sb;

    rgb_to_hsl_convert #(.FRACTION_BITS(FB)) i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // stall the result side at random, except in the no-idle stretch
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 35);
    end

    // idle first at random, then hold one beat until accepted
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while (!no_idle && $urandom_range(99) < 35)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_pixel({b, g, r});
    endtask

    task automatic wait_drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] v;
        sb       = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        no_idle  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, grays, ties and each maximal channel
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd200, 8'd50, 8'd100);
        send_pixel(8'd50, 8'd200, 8'd100);
        send_pixel(8'd100, 8'd50, 8'd200);
        send_pixel(8'd127, 8'd128, 8'd0);
        send_pixel(8'd128, 8'd127, 8'd255);
        send_pixel(8'd170, 8'd85, 8'd85);
        s_tvalid <= 1'b0;

        // hold off until the pipeline has drained
        wait_drain();

        for (int i = 0; i < N_RAND; i++) begin
            no_idle = (i >= 600 && i < 900);
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
            v = 8'($urandom);
            case ($urandom_range(9))
                0: begin g = r; b = r; end
                1: g = r;
                2: b = g;
                3: begin r = v | 8'hF0; end
                4: begin r = v & 8'h0F; g = 8'($urandom_range(15)); end
                default: ;
            endcase
            send_pixel(r, g, b);
        end
        s_tvalid <= 1'b0;
        no_idle = 1'b0;
        wait_drain();
        repeat (2 * LAT) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
